// ===== rtl/core/trfp_pkg.sv =====
// Shared types, codes and tag tables of the tagged response field parser.
package trfp_pkg;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int HOLD_DEPTH  = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0]  FIELD_MAX = 8'd255;
    localparam logic [10:0] RSSI_MAX  = 11'd1024;

    // One result as it travels from the parser to the output stage.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [8:0]  count;
        logic [7:0]  size;
        logic [10:0] rssi_mag;
        logic        rssi_neg;
        logic [7:0]  sf;
        logic [7:0]  cr;
    } trfp_item_t;

    // Tags in matching order: Payload, Size, RSSI, SF, CR.
    function automatic logic [3:0] tag_len(input logic [2:0] t);
        logic [3:0] len;
        case (t)
            3'd0:    len = 4'd9;
            3'd1:    len = 4'd6;
            3'd2:    len = 4'd6;
            3'd3:    len = 4'd4;
            3'd4:    len = 4'd4;
            default: len = 4'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] tag_char(input logic [2:0] t, input logic [3:0] i);
        logic [71:0] text;
        logic [7:0]  ch;
        case (t)
            3'd0:    text = "/Payload/";
            3'd1:    text = {24'd0, "/Size/"};
            3'd2:    text = {24'd0, "/RSSI/"};
            3'd3:    text = {40'd0, "/SF/"};
            3'd4:    text = {40'd0, "/CR/"};
            default: text = '0;
        endcase
        // The first character sits in the highest byte of the tag's own length.
        ch = '0;
        if (i < tag_len(t)) begin
            ch = text[8 * (tag_len(t) - 4'd1 - i) +: 8];
        end
        return ch;
    endfunction

endpackage

// ===== rtl/core/tagged_response_field_parser_unit.sv =====
// Top level of the tagged response field parser: front, result queue and output stage.
// out_valid follows an accepted input beat through the result queue and the output register.
// Throughput: one input byte per cycle; in_stall rises only while the two-entry result
// queue is full, and with a result on every beat any stalled output cycle fills it.
// Reset (rst_n low, asynchronous) returns the parser to seeking the Payload tag and
// empties the queue and the output register; the hold window needs no reset.
module tagged_response_field_parser_unit #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         result_kind,
    output logic [7:0]         data_byte,
    output logic [8:0]         payload_count,
    output logic [7:0]         declared_size,
    output logic signed [10:0] signal_strength,
    output logic [7:0]         spread_factor,
    output logic [7:0]         code_rate
);
    import trfp_pkg::*;

    trfp_item_t push_item;
    trfp_item_t head;
    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;

    assign in_stall = q_full;

    trfp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .rx_byte   (rx_byte),
        .fifo_full (q_full),
        .push      (push),
        .item      (push_item)
    );

    trfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    trfp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .empty           (q_empty),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .data_byte       (data_byte),
        .payload_count   (payload_count),
        .declared_size   (declared_size),
        .signal_strength (signal_strength),
        .spread_factor   (spread_factor),
        .code_rate       (code_rate)
    );

endmodule

// ===== rtl/core/trfp_front.sv =====
// Parser front: tag matching, payload hold window and decimal field accumulation.
module trfp_front #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          rx_byte,
    input  logic                fifo_full,
    output logic                push,
    output trfp_pkg::trfp_item_t item
);
    import trfp_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int EXT_W = CNT_W + 9;

    localparam logic [2:0] PH_SEEK    = 3'd0;
    localparam logic [2:0] PH_PAYLOAD = 3'd1;
    localparam logic [2:0] PH_SIZE    = 3'd2;
    localparam logic [2:0] PH_RSSI    = 3'd3;
    localparam logic [2:0] PH_SF      = 3'd4;
    localparam logic [2:0] PH_CR      = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic [3:0]       tmi_reg, tmi_next;
    logic [2:0]       hold_cnt_reg, hold_cnt_next;
    logic [CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [7:0]       size_reg, size_next;
    logic [10:0]      rssi_reg, rssi_next;
    logic             neg_reg, neg_next;
    logic [7:0]       sf_reg, sf_next;
    logic [7:0]       cr_reg, cr_next;
    logic             slash_reg, slash_next;
    logic [7:0]       hold_reg [HOLD_DEPTH];

    logic             accept;
    logic             shift_en;
    logic [2:0]       ph;
    logic [3:0]       len;
    logic [3:0]       idx0;
    logic [3:0]       m;
    logic             done;
    logic [3:0]       m_next;
    logic             is_digit;
    logic [3:0]       digit;
    logic [11:0]      size_sum, sf_sum, cr_sum;
    logic [13:0]      rssi_sum;
    logic [EXT_W-1:0] cnt_ext;

    assign accept   = in_valid && !fifo_full;
    assign ph       = (phase_reg > PH_CR) ? PH_SEEK : phase_reg;
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign digit    = 4'(rx_byte - CH_ZERO);
    assign cnt_ext  = EXT_W'(byte_cnt_reg);

    assign size_sum = 12'(size_reg) * 12'd10 + 12'(digit);
    assign sf_sum   = 12'(sf_reg) * 12'd10 + 12'(digit);
    assign cr_sum   = 12'(cr_reg) * 12'd10 + 12'(digit);
    assign rssi_sum = 14'(rssi_reg) * 14'd10 + 14'(digit);

    // One step of the running tag match for the tag of the current phase.
    always_comb
    begin
        len  = tag_len(ph);
        idx0 = (tmi_reg >= len) ? 4'd0 : tmi_reg;
        if (rx_byte == tag_char(ph, idx0))
        begin
            m = idx0 + 4'd1;
        end
        else
        begin
            m = (rx_byte == CH_SLASH) ? 4'd1 : 4'd0;
        end
        done   = (m == len);
        m_next = done ? 4'd0 : m;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        tmi_next      = tmi_reg;
        hold_cnt_next = hold_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        size_next     = size_reg;
        rssi_next     = rssi_reg;
        neg_next      = neg_reg;
        sf_next       = sf_reg;
        cr_next       = cr_reg;
        slash_next    = slash_reg;
        shift_en      = 1'b0;
        push          = 1'b0;
        item          = '0;

        if (accept)
        begin
            slash_next = (rx_byte == CH_SLASH);
            if (ph == PH_SEEK)
            begin
                tmi_next = m_next;
                if (done)
                begin
                    tmi_next      = '0;
                    hold_cnt_next = '0;
                    byte_cnt_next = '0;
                    size_next     = '0;
                    rssi_next     = '0;
                    neg_next      = 1'b0;
                    sf_next       = '0;
                    cr_next       = '0;
                    phase_next    = PH_PAYLOAD;
                end
            end
            else if (slash_reg && rx_byte == CH_SEMI)
            begin
                // End mark: a summary only once the CR field has begun.
                push = 1'b1;
                if (ph == PH_CR)
                begin
                    item.kind     = KIND_SUMMARY;
                    item.count    = cnt_ext[8:0];
                    item.size     = size_reg;
                    item.rssi_mag = rssi_reg;
                    item.rssi_neg = neg_reg;
                    item.sf       = sf_reg;
                    item.cr       = cr_reg;
                end
                else
                begin
                    item.kind = KIND_ERROR;
                end
                tmi_next      = '0;
                hold_cnt_next = '0;
                byte_cnt_next = '0;
                size_next     = '0;
                rssi_next     = '0;
                neg_next      = 1'b0;
                sf_next       = '0;
                cr_next       = '0;
                phase_next    = PH_SEEK;
            end
            else if (ph == PH_PAYLOAD)
            begin
                tmi_next = m_next;
                if (done)
                begin
                    // The held bytes are the Size tag itself and are dropped.
                    hold_cnt_next = '0;
                    phase_next    = PH_SIZE;
                end
                else if (hold_cnt_reg < 3'(HOLD_DEPTH))
                begin
                    shift_en      = 1'b1;
                    hold_cnt_next = hold_cnt_reg + 3'd1;
                end
                else
                begin
                    shift_en = 1'b1;
                    push     = 1'b1;
                    if (byte_cnt_reg >= CNT_W'(MAX_PAYLOAD))
                    begin
                        item.kind     = KIND_ERROR;
                        tmi_next      = '0;
                        hold_cnt_next = '0;
                        byte_cnt_next = '0;
                        size_next     = '0;
                        rssi_next     = '0;
                        neg_next      = 1'b0;
                        sf_next       = '0;
                        cr_next       = '0;
                        phase_next    = PH_SEEK;
                    end
                    else
                    begin
                        item.kind     = KIND_DATA;
                        item.data     = hold_reg[0];
                        byte_cnt_next = byte_cnt_reg + CNT_W'(1);
                    end
                end
            end
            else
            begin
                if (is_digit)
                begin
                    case (ph)
                        PH_SIZE:
                            size_next = (size_sum > 12'(FIELD_MAX)) ? FIELD_MAX : size_sum[7:0];
                        PH_RSSI:
                            rssi_next = (rssi_sum > 14'(RSSI_MAX)) ? RSSI_MAX : rssi_sum[10:0];
                        PH_SF:
                            sf_next = (sf_sum > 12'(FIELD_MAX)) ? FIELD_MAX : sf_sum[7:0];
                        default:
                            cr_next = (cr_sum > 12'(FIELD_MAX)) ? FIELD_MAX : cr_sum[7:0];
                    endcase
                end
                else if (rx_byte == CH_MINUS && ph == PH_RSSI)
                begin
                    neg_next = 1'b1;
                end
                if (ph != PH_CR)
                begin
                    tmi_next = m_next;
                    if (done)
                    begin
                        phase_next = ph + 3'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SEEK;
            tmi_reg      <= '0;
            hold_cnt_reg <= '0;
            byte_cnt_reg <= '0;
            size_reg     <= '0;
            rssi_reg     <= '0;
            neg_reg      <= 1'b0;
            sf_reg       <= '0;
            cr_reg       <= '0;
            slash_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            tmi_reg      <= tmi_next;
            hold_cnt_reg <= hold_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
            size_reg     <= size_next;
            rssi_reg     <= rssi_next;
            neg_reg      <= neg_next;
            sf_reg       <= sf_next;
            cr_reg       <= cr_next;
            slash_reg    <= slash_next;
        end
    end

    // Bytes enter at the top; once the window is full the bottom entry is the oldest.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < HOLD_DEPTH - 1; i++)
            begin
                hold_reg[i] <= hold_reg[i + 1];
            end
            hold_reg[HOLD_DEPTH - 1] <= rx_byte;
        end
    end

    a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hold_cnt_reg <= 3'(HOLD_DEPTH))
        else $error("hold window count out of range");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_cnt_reg <= CNT_W'(MAX_PAYLOAD))
        else $error("payload byte count beyond limit");

    a_end_reseek: assert property (@(posedge clk) disable iff (!rst_n)
        push && item.kind != KIND_DATA |=> phase_reg == PH_SEEK)
        else $error("parser did not return to seeking after a summary or error");

endmodule

// ===== rtl/core/trfp_queue.sv =====
// Short result queue between the parser front and the output stage.
module trfp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  trfp_pkg::trfp_item_t push_item,
    input  logic                 pop,
    output trfp_pkg::trfp_item_t head,
    output logic                 empty,
    output logic                 full
);
    import trfp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    trfp_item_t       store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("result queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("result queue read while empty");

endmodule

// ===== rtl/core/trfp_back.sv =====
// Output stage: takes queued results, finishes the RSSI value and holds the outgoing beat.
module trfp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  trfp_pkg::trfp_item_t head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           result_kind,
    output logic [7:0]           data_byte,
    output logic [8:0]           payload_count,
    output logic [7:0]           declared_size,
    output logic signed [10:0]   signal_strength,
    output logic [7:0]           spread_factor,
    output logic [7:0]           code_rate
);
    import trfp_pkg::*;

    logic               valid_reg, valid_next;
    logic [1:0]         kind_reg;
    logic [7:0]         data_reg;
    logic [8:0]         count_reg;
    logic [7:0]         size_reg;
    logic signed [10:0] rssi_reg;
    logic [7:0]         sf_reg;
    logic [7:0]         cr_reg;
    logic signed [10:0] rssi_value;

    // A magnitude of 1024 wraps to -1024 when negative and clips to 1023 otherwise.
    assign rssi_value = head.rssi_neg ? $signed(11'd0 - head.rssi_mag)
                      : (head.rssi_mag[10] ? 11'sd1023 : $signed(head.rssi_mag));

    assign pop        = !empty && (!valid_reg || !out_stall);
    assign valid_next = pop ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= head.kind;
            data_reg  <= head.data;
            count_reg <= head.count;
            size_reg  <= head.size;
            rssi_reg  <= rssi_value;
            sf_reg    <= head.sf;
            cr_reg    <= head.cr;
        end
    end

    assign out_valid       = valid_reg;
    assign result_kind     = kind_reg;
    assign data_byte       = data_reg;
    assign payload_count   = count_reg;
    assign declared_size   = size_reg;
    assign signal_strength = rssi_reg;
    assign spread_factor   = sf_reg;
    assign code_rate       = cr_reg;

endmodule

// ===== verif/trfp_result_checker.sv =====
// Checker for the tagged response field parser: predicts results from input beats and compares.
module trfp_result_checker #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         result_kind,
    input  logic [7:0]         data_byte,
    input  logic [8:0]         payload_count,
    input  logic [7:0]         declared_size,
    input  logic signed [10:0] signal_strength,
    input  logic [7:0]         spread_factor,
    input  logic [7:0]         code_rate,
    output int                 fail_count,
    output int                 pending,
    output int                 data_seen,
    output int                 summary_seen,
    output int                 error_seen
);
    import trfp_pkg::*;

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_PAYLOAD,
        PH_SIZE,
        PH_RSSI,
        PH_SF,
        PH_CR
    } parse_phase_e;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [8:0]  count;
        logic [7:0]  size;
        logic [10:0] rssi;
        logic [7:0]  sf;
        logic [7:0]  cr;
    } parser_result_t;

    // Tag i ends the phase whose code is i.
    string tag_text [5] = '{"/Payload/", "/Size/", "/RSSI/", "/SF/", "/CR/"};

    parser_result_t expected_results [$];

    parse_phase_e ph;
    int unsigned  tag_idx;
    logic [7:0]   window [HOLD_DEPTH];
    int unsigned  held;
    int unsigned  emitted;
    int unsigned  size_v;
    int unsigned  rssi_v;
    int unsigned  sf_v;
    int unsigned  cr_v;
    bit           rssi_minus;
    bit           last_slash;

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        data_seen    = 0;
        summary_seen = 0;
        error_seen   = 0;
    end

    task automatic report(input string msg);
        if (fail_count < 30)
        begin
            $display("[%0t] result mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    task automatic clear_frame();
        tag_idx    = 0;
        held       = 0;
        emitted    = 0;
        size_v     = 0;
        rssi_v     = 0;
        sf_v       = 0;
        cr_v       = 0;
        rssi_minus = 1'b0;
    endtask

    function automatic int unsigned sat_dec(input int unsigned acc, input int unsigned digit,
                                            input int unsigned limit);
        int unsigned v;
        v = acc * 10 + digit;
        return (v > limit) ? limit : v;
    endfunction

    // Moves the match of tag t on by one byte; true once the whole tag has been seen.
    function automatic bit advance_tag(input int t, input logic [7:0] b);
        int unsigned len;
        len = tag_text[t].len();
        if (tag_idx >= len)
        begin
            tag_idx = 0;
        end
        if (b == tag_text[t][tag_idx])
        begin
            tag_idx++;
        end
        else
        begin
            tag_idx = (b == CH_SLASH) ? 1 : 0;
        end
        if (tag_idx == len)
        begin
            tag_idx = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic parse_byte(input logic [7:0] b);
        bit             prev_slash;
        logic [7:0]     oldest;
        parser_result_t r;
        int unsigned    d;
        int             i;
        prev_slash = last_slash;
        last_slash = (b == CH_SLASH);
        r = '0;

        if (ph == PH_SEEK)
        begin
            if (advance_tag(0, b))
            begin
                clear_frame();
                ph = PH_PAYLOAD;
            end
            return;
        end

        if (prev_slash && b == CH_SEMI)
        begin
            if (ph == PH_CR)
            begin
                r.kind  = KIND_SUMMARY;
                r.count = 9'(emitted);
                r.size  = 8'(size_v);
                r.rssi  = rssi_minus ? 11'(0 - rssi_v)
                                     : ((rssi_v > 1023) ? 11'd1023 : 11'(rssi_v));
                r.sf    = 8'(sf_v);
                r.cr    = 8'(cr_v);
            end
            else
            begin
                r.kind = KIND_ERROR;
            end
            expected_results.push_back(r);
            clear_frame();
            ph = PH_SEEK;
            return;
        end

        if (ph == PH_PAYLOAD)
        begin
            // The held bytes turn out to be the Size tag itself and are dropped.
            if (advance_tag(1, b))
            begin
                held = 0;
                ph   = PH_SIZE;
                return;
            end
            if (held < HOLD_DEPTH)
            begin
                window[held] = b;
                held++;
                return;
            end
            oldest = window[0];
            for (i = 0; i < HOLD_DEPTH - 1; i++)
            begin
                window[i] = window[i + 1];
            end
            window[HOLD_DEPTH - 1] = b;
            if (emitted >= MAX_PAYLOAD)
            begin
                r.kind = KIND_ERROR;
                expected_results.push_back(r);
                clear_frame();
                ph = PH_SEEK;
                return;
            end
            emitted++;
            r.kind = KIND_DATA;
            r.data = oldest;
            expected_results.push_back(r);
            return;
        end

        if (b >= CH_ZERO && b <= CH_NINE)
        begin
            d = b - CH_ZERO;
            case (ph)
                PH_SIZE: size_v = sat_dec(size_v, d, 255);
                PH_RSSI: rssi_v = sat_dec(rssi_v, d, 1024);
                PH_SF:   sf_v   = sat_dec(sf_v, d, 255);
                default: cr_v   = sat_dec(cr_v, d, 255);
            endcase
        end
        else if (b == CH_MINUS && ph == PH_RSSI)
        begin
            rssi_minus = 1'b1;
        end

        if (ph != PH_CR && advance_tag(int'(ph), b))
        begin
            ph = parse_phase_e'(int'(ph) + 1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        parser_result_t got;
        parser_result_t want;
        if (!rst_n)
        begin
            clear_frame();
            ph         = PH_SEEK;
            last_slash = 1'b0;
            expected_results.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                parse_byte(rx_byte);
            end
            if (out_valid && !out_stall)
            begin
                got.kind  = result_kind;
                got.data  = data_byte;
                got.count = payload_count;
                got.size  = declared_size;
                got.rssi  = signal_strength;
                got.sf    = spread_factor;
                got.cr    = code_rate;
                case (got.kind)
                    KIND_DATA:    data_seen++;
                    KIND_SUMMARY: summary_seen++;
                    default:      error_seen++;
                endcase
                if (expected_results.size() == 0)
                begin
                    report($sformatf("result beat of kind %0d with nothing expected", got.kind));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind)
                        report($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
                    if (got.data !== want.data)
                        report($sformatf("data_byte %0h, want %0h", got.data, want.data));
                    if (got.count !== want.count)
                        report($sformatf("payload_count %0d, want %0d", got.count, want.count));
                    if (got.size !== want.size)
                        report($sformatf("declared_size %0d, want %0d", got.size, want.size));
                    if (got.rssi !== want.rssi)
                        report($sformatf("signal_strength %0h, want %0h", got.rssi, want.rssi));
                    if (got.sf !== want.sf)
                        report($sformatf("spread_factor %0d, want %0d", got.sf, want.sf));
                    if (got.cr !== want.cr)
                        report($sformatf("code_rate %0d, want %0d", got.cr, want.cr));
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== verif/tb_tagged_response_field_parser_unit.sv =====
// Testbench top of the tagged response field parser: reset, clock, reply stimulus and verdict.
module tb_tagged_response_field_parser_unit;
    import trfp_pkg::*;

    localparam int MAX_PAYLOAD     = 256;
    localparam int ITEM_TARGET     = 1550;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RUN_LIMIT       = 4800000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         result_kind;
    logic [7:0]         data_byte;
    logic [8:0]         payload_count;
    logic [7:0]         declared_size;
    logic signed [10:0] signal_strength;
    logic [7:0]         spread_factor;
    logic [7:0]         code_rate;

    int fail_count;
    int pending;
    int data_seen;
    int summary_seen;
    int error_seen;

    int send_idle_pct;
    int stall_pct;
    int hold_reqs;
    int beats_sent;
    int replies_sent;

    logic [7:0] reply_bytes [$];

    tagged_response_field_parser_unit #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_kind(result_kind),
        .data_byte(data_byte),
        .payload_count(payload_count),
        .declared_size(declared_size),
        .signal_strength(signal_strength),
        .spread_factor(spread_factor),
        .code_rate(code_rate)
    );

    trfp_result_checker #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) result_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_kind(result_kind),
        .data_byte(data_byte),
        .payload_count(payload_count),
        .declared_size(declared_size),
        .signal_strength(signal_strength),
        .spread_factor(spread_factor),
        .code_rate(code_rate),
        .fail_count(fail_count),
        .pending(pending),
        .data_seen(data_seen),
        .summary_seen(summary_seen),
        .error_seen(error_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin : receiver
        int served;
        served = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != served)
            begin
                served = hold_reqs;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_reply();
        while (reply_bytes.size() > 0)
        begin
            send_byte(reply_bytes.pop_front());
        end
        replies_sent++;
    endtask

    // Stops offering beats until every predicted result has come out.
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            reply_bytes.push_back(s[i]);
        end
    endtask

    task automatic push_noise(input int n);
        int i;
        int sel;
        for (i = 0; i < n; i++)
        begin
            sel = $urandom_range(9);
            if (sel < 2)
                reply_bytes.push_back(CH_SLASH);
            else if (sel == 2)
                reply_bytes.push_back(CH_SEMI);
            else
                reply_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    // Mostly printable characters without a slash; a clean payload never carries a tag.
    task automatic push_payload(input int n, input bit clean);
        int         i;
        logic [7:0] ch;
        for (i = 0; i < n; i++)
        begin
            if (clean || $urandom_range(99) < 80)
            begin
                ch = 8'($urandom_range(8'h20, 8'h7E));
                if (ch == CH_SLASH)
                    ch = 8'h5F;
            end
            else
            begin
                ch = 8'($urandom_range(255));
            end
            reply_bytes.push_back(ch);
        end
    endtask

    task automatic push_number(input int minus_pct);
        int sel;
        int n;
        int i;
        sel = $urandom_range(9);
        n   = (sel == 0) ? 0 : (sel < 8) ? $urandom_range(1, 3) : $urandom_range(4, 6);
        if ($urandom_range(99) < minus_pct)
            reply_bytes.push_back(CH_MINUS);
        for (i = 0; i < n; i++)
        begin
            reply_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
        if ($urandom_range(9) == 0)
            reply_bytes.push_back(8'($urandom_range(8'h41, 8'h7A)));
    endtask

    task automatic push_fields();
        push_text("/Size/");
        push_number(5);
        push_text("/RSSI/");
        push_number(50);
        push_text("/SF/");
        push_number(5);
        push_text("/CR/");
        push_number(5);
    endtask

    task automatic build_reply();
        int shape;
        int cut;
        shape = $urandom_range(99);
        if ($urandom_range(3) == 0)
            push_noise($urandom_range(1, 4));
        if (shape < 10)
        begin
            push_noise($urandom_range(3, 12));
            return;
        end
        push_text("/Payload/");
        push_payload(($urandom_range(99) < 70) ? $urandom_range(0, 8) : $urandom_range(9, 30), 0);
        push_fields();
        if (shape < 25)
        begin
            // Broken reply: cut short, then either an early end mark or nothing at all.
            cut = $urandom_range(10, reply_bytes.size() - 1);
            while (reply_bytes.size() > cut)
            begin
                void'(reply_bytes.pop_back());
            end
            if (shape < 18)
                push_text("/;");
        end
        else
        begin
            push_text("/;");
        end
    endtask

    initial
    begin : stimulus
        int mix;
        int last_mix;
        int idle_mix [4];
        int stall_mix [4];
        idle_mix  = '{0, 45, 0, 18};
        stall_mix = '{0, 0, 45, 18};
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rx_byte   <= 8'h00;
        stall_pct <= 0;
        hold_reqs <= 0;
        send_idle_pct = 0;
        beats_sent    = 0;
        replies_sent  = 0;
        last_mix      = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme bytes and an end mark while still seeking, then one reply with saturating fields.
        send_byte(8'h00);
        send_byte(8'hFF);
        push_text("/;/Payload/Q/Size/999/RSSI/-9999/SF//CR/300/;");
        send_reply();

        while (beats_sent < ITEM_TARGET)
        begin
            mix = beats_sent * 4 / ITEM_TARGET;
            if (mix > 3)
                mix = 3;
            if (mix != last_mix)
            begin
                quiesce();
                send_idle_pct = idle_mix[mix];
                stall_pct <= stall_mix[mix];
                last_mix = mix;
            end
            if (replies_sent == 3)
            begin
                // Longest payload that still fits, sent against a long output hold-off.
                hold_reqs <= hold_reqs + 1;
                push_text("/Payload/");
                push_payload(MAX_PAYLOAD, 1);
                push_fields();
                push_text("/;");
            end
            else if (replies_sent == 6)
            begin
                quiesce();
                push_text("/Payload/");
                push_payload(MAX_PAYLOAD + 1, 1);
                push_fields();
                push_text("/;");
            end
            else
            begin
                build_reply();
            end
            send_reply();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input beats in %0d replies over four idling mixes and a long hold-off.",
                 beats_sent, replies_sent);
        $display("Checked %0d payload bytes, %0d packet summaries and %0d error results.",
                 data_seen, summary_seen, error_seen);
        if (fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
